// ----- hw/rtl/rglp_pkg.sv -----
// Package for the replay guard with wear-leveled slot persistence.
// Holds the slot geometry, the transaction payload types and the register map.
// Used by every module under hw/rtl; depends on nothing.
package rglp_pkg;

  // Slot ring geometry.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SEQ_W      = 32;
  localparam int SLOT_FLD_W = 3;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [SEQ_W-1:0]      seq_t;

  localparam slot_idx_t SLOT_LAST = slot_idx_t'(SLOT_COUNT - 1);

  // Input transaction opcodes.
  localparam logic OP_CHECK   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Configuration port: one 32-bit register, byte addressed, word aligned.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAP_AMOUNT = '0;
  localparam seq_t LEAP_RESET = seq_t'(1024);

  typedef struct packed {
    logic opcode;
    seq_t received_seq;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    seq_t                  expected_seq;
    seq_t                  persisted_seq;
    logic                  slot_written;
    logic [SLOT_FLD_W-1:0] written_slot;
  } out_item_t;

  // Slot write port between the sequencer and the slot bank.
  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    seq_t      data;
  } slot_wr_t;

  // Low bits of a slot index as carried in the result field.
  function automatic logic [SLOT_FLD_W-1:0] slot_field(input slot_idx_t idx);
    logic [SLOT_IDX_W+SLOT_FLD_W-1:0] ext;
    ext = (SLOT_IDX_W + SLOT_FLD_W)'(idx);
    return ext[SLOT_FLD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/rglp_cfg_regs.sv -----
// APB-style configuration register block of the replay guard.
// Holds the leap amount; depends on rglp_pkg.
module rglp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rglp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rglp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rglp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rglp_pkg::seq_t                 leap_amount
);
  import rglp_pkg::*;

  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;
  seq_t                 leap_r;
  seq_t                 leap_nxt;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;

  // A write transaction lands in the access phase.
  assign wr_hit   = psel && penable && pwrite && (reg_idx == REG_LEAP_AMOUNT);
  assign leap_nxt = wr_hit ? seq_t'(pwdata) : leap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= LEAP_RESET;
    end else begin
      leap_r <= leap_nxt;
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_LEAP_AMOUNT) begin
      prdata = CFG_DATA_W'(leap_r);
    end
  end

  assign leap_amount = leap_r;

endmodule

// ----- hw/rtl/rglp_slot_bank.sv -----
// Non-volatile slot ring of the replay guard, modeled as a register bank.
// One write port and one scan read port; depends on rglp_pkg.
module rglp_slot_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  rglp_pkg::slot_wr_t wr,
  input  rglp_pkg::slot_idx_t rd_addr,
  output rglp_pkg::seq_t     rd_data
);
  import rglp_pkg::*;

  seq_t slot_r [SLOT_COUNT];

  // Slots are cleared at reset and written one at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        slot_r[k] <= '0;
      end
    end else if (wr.en) begin
      slot_r[wr.addr] <= wr.data;
    end
  end

  // The scan reads one slot per cycle.
  assign rd_data = slot_r[rd_addr];

endmodule

// ----- hw/rtl/replay_guard_leap_persist.sv -----
// Replay guard top level: sequencer around one shared 32-bit comparator.
// Depends on rglp_pkg, rglp_cfg_regs and rglp_slot_bank.
//
// Each transaction is handled on its own; in_ready is high only while the block is idle.
// A rejected check goes from the check step straight to the result, and an accepted check
// that does not persist goes through the check and guard steps. A restart walks the slot
// ring one slot per cycle through the single comparator. A persisting check adds the check,
// guard and slot write steps to the walk. The result waits in the output registers until
// it is taken, and the next transaction is accepted from the idle state after that. Slots
// are cleared by reset directly, so no clearing pass is needed. The user must write
// leap_amount through the APB-style port only while the block is idle; the block itself
// does not enforce this.
module replay_guard_leap_persist (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rglp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rglp_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rglp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rglp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rglp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rglp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_GUARD = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t    state_r, state_nxt;
  logic      op_r, op_nxt;
  seq_t      seq_r, seq_nxt;
  seq_t      exp_r, exp_nxt;
  seq_t      pers_r, pers_nxt;
  seq_t      max_r, max_nxt;
  slot_idx_t at_r, at_nxt;
  slot_idx_t idx_r, idx_nxt;
  logic      acc_r, acc_nxt;
  logic      wrote_r, wrote_nxt;
  logic [SLOT_FLD_W-1:0] where_r, where_nxt;

  seq_t      leap_amount;
  seq_t      slot_rd;
  seq_t      leap_val;
  slot_idx_t after_max;
  slot_wr_t  slot_wr;
  seq_t      cmp_a, cmp_b;
  logic      cmp_gt;

  rglp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .leap_amount (leap_amount)
  );

  rglp_slot_bank u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (slot_wr),
    .rd_addr (idx_r),
    .rd_data (slot_rd)
  );

  // Shared comparator; the operands follow the sequencer step.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      ST_CHECK: begin
        cmp_a = exp_r;
        cmp_b = seq_r;
      end
      ST_GUARD: begin
        cmp_a = pers_r;
        cmp_b = exp_r;
      end
      ST_SCAN: begin
        cmp_a = slot_rd;
        cmp_b = max_r;
      end
      ST_WRITE: begin
        cmp_a = leap_val;
        cmp_b = max_r;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  // New persisted candidate and the slot that follows the first highest one.
  assign leap_val  = exp_r + leap_amount;
  assign after_max = (at_r == SLOT_LAST) ? '0 : slot_idx_t'(at_r + 1'b1);

  always_comb begin
    slot_wr.en   = (state_r == ST_WRITE);
    slot_wr.addr = after_max;
    slot_wr.data = leap_val;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    seq_nxt   = seq_r;
    exp_nxt   = exp_r;
    pers_nxt  = pers_r;
    max_nxt   = max_r;
    at_nxt    = at_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    wrote_nxt = wrote_r;
    where_nxt = where_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          seq_nxt   = in_data.received_seq;
          acc_nxt   = 1'b0;
          wrote_nxt = 1'b0;
          where_nxt = '0;
          max_nxt   = '0;
          at_nxt    = '0;
          idx_nxt   = '0;
          state_nxt = (in_data.opcode == OP_RESTART) ? ST_SCAN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Not below the expected value means no replay.
        if (!cmp_gt) begin
          acc_nxt   = 1'b1;
          state_nxt = ST_GUARD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_GUARD: begin
        // Persist only once the expected value has caught up.
        if (!cmp_gt) begin
          state_nxt = ST_SCAN;
        end else begin
          exp_nxt   = seq_r;
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        // Track the first highest slot, one slot per cycle.
        if (cmp_gt) begin
          max_nxt = slot_rd;
          at_nxt  = idx_r;
        end
        if (idx_r == SLOT_LAST) begin
          if (op_r == OP_RESTART) begin
            pers_nxt  = cmp_gt ? slot_rd : max_r;
            exp_nxt   = cmp_gt ? slot_rd : max_r;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WRITE;
          end
        end else begin
          idx_nxt = slot_idx_t'(idx_r + 1'b1);
        end
      end
      ST_WRITE: begin
        // The highest slot is untouched, so the new maximum is one compare away.
        pers_nxt  = cmp_gt ? leap_val : max_r;
        exp_nxt   = seq_r;
        wrote_nxt = 1'b1;
        where_nxt = slot_field(after_max);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      exp_r   <= '0;
      pers_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      pers_r  <= pers_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    seq_r   <= seq_nxt;
    max_r   <= max_nxt;
    at_r    <= at_nxt;
    acc_r   <= acc_nxt;
    wrote_r <= wrote_nxt;
    where_r <= where_nxt;
  end

  // Result transaction straight from registers.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    out_data.accepted      = acc_r;
    out_data.expected_seq  = exp_r;
    out_data.persisted_seq = pers_r;
    out_data.slot_written  = wrote_r;
    out_data.written_slot  = where_r;
  end

`ifndef SYNTH
  // A slot is only written for an accepted number.
  a_write_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_written |-> out_data.accepted)
    else $error("slot written for a rejected transaction");

  // With no slot written the slot index reads zero.
  a_where_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.slot_written |-> out_data.written_slot == '0)
    else $error("written_slot nonzero without a write");

  // A restart leaves expected and persisted values equal.
  a_restart_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op_r == OP_RESTART |-> out_data.expected_seq == out_data.persisted_seq)
    else $error("restart result with expected and persisted apart");

  // An accepted number becomes the expected value.
  a_accept_takes_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.expected_seq == seq_r)
    else $error("accepted number not taken as expected value");

  // The slot bank is only written on the way to a result.
  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    slot_wr.en |=> out_valid && out_data.slot_written)
    else $error("slot write without a written result");
`endif

endmodule

// ----- tb/rglp_guard_checker.sv -----
// Checker for the replay guard: watches the input, result and register ports,
// tracks the guard and slot ring state, and compares every result in order.
// Depends on rglp_pkg for the payload types, opcodes and register map.
module rglp_guard_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rglp_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rglp_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rglp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rglp_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [rglp_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              writes_seen,
  output int                              rejects_seen,
  output rglp_pkg::seq_t                  guard_exp,
  output rglp_pkg::seq_t                  guard_pers
);
  timeunit 1ns;
  timeprecision 1ps;
  import rglp_pkg::*;

  // Shadow copy of the guard state and the leap register.
  seq_t      ring[SLOT_COUNT];
  seq_t      exp_val;
  seq_t      pers_val;
  seq_t      leap_val;
  out_item_t awaited_verdicts[$];
  out_item_t predicted;
  out_item_t oldest;

  assign guard_exp  = exp_val;
  assign guard_pers = pers_val;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %s on result %0d: got 0x%08h, want 0x%08h",
             what, results_seen, got, want);
    fail_count++;
  endtask

  function automatic seq_t ring_max();
    seq_t m;
    m = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (ring[k] > m) begin
        m = ring[k];
      end
    end
    return m;
  endfunction

  // One guard step: a restart reloads from the ring, an accepted check may
  // persist the old expected value plus the leap after the first highest slot.
  task automatic guard_step(input in_item_t it, output out_item_t r);
    seq_t top_val;
    int   top_at;
    r = '0;
    if (it.opcode == OP_RESTART) begin
      pers_val = ring_max();
      exp_val  = pers_val;
    end else if (it.received_seq >= exp_val) begin
      r.accepted = 1'b1;
      if (exp_val >= pers_val) begin
        top_val = '0;
        top_at  = 0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (ring[k] > top_val) begin
            top_val = ring[k];
            top_at  = k;
          end
        end
        top_at         = (top_at + 1) % SLOT_COUNT;
        ring[top_at]   = exp_val + leap_val;
        r.slot_written = 1'b1;
        r.written_slot = SLOT_FLD_W'(top_at);
        pers_val       = ring_max();
      end
      exp_val = it.received_seq;
    end
    r.expected_seq  = exp_val;
    r.persisted_seq = pers_val;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        ring[k] = '0;
      end
      exp_val      = '0;
      pers_val     = '0;
      leap_val     = LEAP_RESET;
      fail_count   = 0;
      results_seen = 0;
      writes_seen  = 0;
      rejects_seen = 0;
      awaited_verdicts.delete();
    end else begin
      // Register port: track writes, check reads of the leap register.
      if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_LEAP_AMOUNT) begin
        if (pwrite) begin
          leap_val = pwdata;
        end else if (prdata !== leap_val) begin
          report_mismatch("leap_amount readback", prdata, leap_val);
        end
      end

      // Accepted input transaction: predict its result.
      if (in_valid && in_ready) begin
        guard_step(in_data, predicted);
        awaited_verdicts.push_back(predicted);
        if (predicted.slot_written) begin
          writes_seen++;
        end
        if (in_data.opcode == OP_CHECK && !predicted.accepted) begin
          rejects_seen++;
        end
      end

      // Accepted result transaction: compare with the oldest prediction.
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("result with none awaited", out_data.expected_seq, '0);
        end else begin
          oldest = awaited_verdicts.pop_front();
          if (out_data.accepted !== oldest.accepted) begin
            report_mismatch("accepted", 32'(out_data.accepted), 32'(oldest.accepted));
          end
          if (out_data.expected_seq !== oldest.expected_seq) begin
            report_mismatch("expected_seq", out_data.expected_seq, oldest.expected_seq);
          end
          if (out_data.persisted_seq !== oldest.persisted_seq) begin
            report_mismatch("persisted_seq", out_data.persisted_seq, oldest.persisted_seq);
          end
          if (out_data.slot_written !== oldest.slot_written) begin
            report_mismatch("slot_written", 32'(out_data.slot_written),
                            32'(oldest.slot_written));
          end
          if (out_data.written_slot !== oldest.written_slot) begin
            report_mismatch("written_slot", 32'(out_data.written_slot),
                            32'(oldest.written_slot));
          end
        end
      end
    end
    pending = awaited_verdicts.size();
  end

endmodule

// ----- tb/replay_guard_leap_persist_test.sv -----
// Top of the replay guard testbench: clock, reset, stimulus and the verdict.
// Depends on rglp_pkg, the replay_guard_leap_persist block and rglp_guard_checker.
module replay_guard_leap_persist_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rglp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 305;
  localparam int PHASE_COUNT  = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

  typedef enum {SRC_ABS, SRC_EXP_REL, SRC_RESTART, SRC_RANDOM} item_src_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   guard_fails;
  int   guard_pending;
  int   results_seen;
  int   writes_seen;
  int   rejects_seen;
  seq_t guard_exp;
  seq_t guard_pers;

  int cycle_count = 0;
  int burst_left  = 8;
  int rx_left     = 0;
  int rx_mode     = 0;
  int settings    = 1;
  bit wild_ok     = 1'b0;

  replay_guard_leap_persist uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rglp_guard_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (guard_fails),
    .pending     (guard_pending),
    .results_seen(results_seen),
    .writes_seen (writes_seen),
    .rejects_seen(rejects_seen),
    .guard_exp   (guard_exp),
    .guard_pers  (guard_pers)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: alternate between always ready, light stalls and heavy stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Mostly growing sequence numbers relative to the guard, with replays,
  // restarts and jumps; values near the top of the range only when allowed.
  function automatic in_item_t pick_item();
    int       r;
    seq_t     s;
    in_item_t it;
    r         = $urandom_range(0, 99);
    it.opcode = OP_CHECK;
    if (r < 55) begin
      s = guard_exp + $urandom_range(0, 1500);
    end else if (r < 62) begin
      s = guard_exp;
    end else if (r < 69) begin
      s = guard_pers + $urandom_range(0, 2);
    end else if (r < 80) begin
      s = (guard_exp == 0) ? '0 :
          guard_exp - $urandom_range(1, (guard_exp < 2000) ? guard_exp : 2000);
    end else if (r < 86) begin
      it.opcode = OP_RESTART;
      s         = $urandom;
    end else if (r < 92) begin
      s = wild_ok ? seq_t'($urandom) : guard_exp + $urandom_range(0, 20000);
    end else begin
      s = wild_ok ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                  : guard_exp + $urandom_range(1500, 4000);
    end
    it.received_seq = s;
    return it;
  endfunction

  // Drives one input transaction and waits for its handshake. The payload is
  // formed at the falling edge, after the checker has seen earlier handshakes.
  task automatic send_item(input item_src_t src, input seq_t val);
    in_item_t it;
    int       gap;
    @(negedge clk);
    case (src)
      SRC_ABS:     it = '{opcode: OP_CHECK, received_seq: val};
      SRC_EXP_REL: it = '{opcode: OP_CHECK, received_seq: guard_exp + val};
      SRC_RESTART: it = '{opcode: OP_RESTART, received_seq: val};
      default:     it = pick_item();
    endcase
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 16);
    end
  endtask

  // Holds off the input until every predicted result has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (guard_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_leap(input seq_t leap);
    cfg_access(1'b1, REG_LEAP_AMOUNT, leap);
    cfg_access(1'b0, REG_LEAP_AMOUNT, '0);
  endtask

  initial begin
    seq_t leap;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first write with all slots equal, no-persist accept, replay,
    // wrapped persisted value, restarts, then a full walk around the ring.
    cfg_access(1'b0, REG_LEAP_AMOUNT, '0);
    send_item(SRC_ABS, 32'd0);
    send_item(SRC_ABS, 32'd0);
    send_item(SRC_ABS, 32'd500);
    send_item(SRC_ABS, 32'd1024);
    send_item(SRC_ABS, 32'd1024);
    send_item(SRC_RESTART, 32'd0);
    send_item(SRC_ABS, 32'd100);
    send_item(SRC_ABS, 32'hFFFF_FFFF);
    send_item(SRC_ABS, 32'hFFFF_FFFF);
    send_item(SRC_ABS, 32'd0);
    send_item(SRC_RESTART, 32'hFFFF_FFFF);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      send_item(SRC_EXP_REL, 32'd1024);
    end

    // Zero leap persists the value unchanged; a write past the map is ignored.
    wait_idle();
    set_leap('0);
    cfg_access(1'b1, REG_UNMAPPED, $urandom);
    cfg_access(1'b0, REG_LEAP_AMOUNT, '0);
    send_item(SRC_EXP_REL, 32'd0);
    send_item(SRC_EXP_REL, 32'd5);
    send_item(SRC_RESTART, 32'h5A5A_5A5A);

    // Random phases, one leap setting each; large values only in the last.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: leap = 32'd1;
        1: leap = LEAP_RESET;
        2: leap = '0;
        3: leap = $urandom_range(2, 5000);
        4: leap = 32'hFFFF_FFFF;
        default: leap = $urandom;
      endcase
      set_leap(leap);
      settings++;
      wild_ok = (p == PHASE_COUNT - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) == 0) begin
          wait_idle();
        end
        send_item(SRC_RANDOM, '0);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    $display("run: %0d results checked over %0d leap settings", results_seen, settings);
    $display("run: %0d slot writes, %0d replays rejected", writes_seen, rejects_seen);
    if (guard_fails == 0 && guard_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
